// ===== rtl/block_table_first_fit_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Block table allocator assertion macros
// Concurrent check shorthands clocked on clk, disabled during rst.
// ----------------------------------------------------------------------------
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BTFF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BTFF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/btff_pkg.sv =====
// ----------------------------------------------------------------------------
// btff_pkg
// Shared constants and types of the block table first-fit allocator.
// ----------------------------------------------------------------------------
package btff_pkg;

  localparam int DEF_MAX_BLOCKS  = 4096;
  localparam int DEF_BLOCK_BYTES = 4096;

  localparam int BASE_W      = 20;
  localparam int COUNT_W     = 13;
  localparam int COUNT_RESET = 4096;
  localparam int CFG_W       = 20;
  localparam int ADDR_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int OP_W        = 2;
  localparam int MARK_W      = 3;

  localparam logic [OP_W-1:0] OP_ALLOCATE = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_SIZE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ADDR  = 2'd3;

  localparam logic CFG_BASE_BLOCK  = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  // mark bit positions
  localparam int MARK_TAKEN = 0;
  localparam int MARK_NEXT  = 1;
  localparam int MARK_FIRST = 2;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   granted_address;
  } result_t;

endpackage

// ===== rtl/btff_mark_ram.sv =====
// ----------------------------------------------------------------------------
// btff_mark_ram
// Block mark table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btff_mark_ram
  import btff_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_BLOCKS,
  parameter int AW    = $clog2(DEF_MAX_BLOCKS)
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [MARK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [MARK_W-1:0] wr_data
);

  logic [MARK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/btff_engine.sv =====
// ----------------------------------------------------------------------------
// btff_engine
// Sequencer: clearing sweep, first-fit search, run marking and chain release
// over the mark table, one table entry per cycle.
// ----------------------------------------------------------------------------
module btff_engine
  import btff_pkg::*;
#(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int IDX_W       = $clog2(DEF_MAX_BLOCKS),
  parameter int CNT_W       = $clog2(DEF_MAX_BLOCKS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [OP_W-1:0]   operation,
  input  logic [ADDR_W-1:0] request_bytes,
  input  logic [ADDR_W-1:0] free_address,
  input  logic [BASE_W-1:0] base_block,
  input  logic [CNT_W-1:0]  blocks,
  input  logic              res_ready,
  output logic              idle,
  output logic              res_valid,
  output result_t           res
);

  // BLOCK_BYTES is a power of two
  localparam int SHIFT = $clog2(BLOCK_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_CHECK  = 7'b0000100,
    S_SEARCH = 7'b0001000,
    S_MARK   = 7'b0010000,
    S_FREE   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t            state;
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] bytes_q;
  logic [ADDR_W-1:0] faddr_q;
  logic [CNT_W-1:0]  ra;
  logic              rv;
  logic [IDX_W-1:0]  di;
  logic [CNT_W-1:0]  run;
  logic [CNT_W-1:0]  want_q;
  logic [IDX_W-1:0]  start_q;
  logic [IDX_W-1:0]  last_q;
  logic [IDX_W-1:0]  wa;
  logic              clr_result;
  result_t           res_q;

  logic              issue;
  logic [MARK_W-1:0] rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [MARK_W-1:0] wr_data;
  logic [MARK_W-1:0] mark;
  logic [32:0]       want_full;
  logic [ADDR_W-1:0] faddr_blk;
  logic [32:0]       heap_hi;
  logic              in_range;
  logic [CNT_W-1:0]  run_next;
  logic [IDX_W-1:0]  found_start;
  logic [CNT_W-1:0]  di_next;
  logic [63:0]       addr_wide;

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE) && res_ready;
  assign res       = res_q;

  assign issue = ((state == S_SEARCH) || (state == S_FREE)) && (ra < blocks);

  assign want_full = (33'(bytes_q) + 33'(BLOCK_BYTES - 1)) >> SHIFT;
  assign faddr_blk = faddr_q >> SHIFT;
  assign heap_hi   = 33'(base_block) + 33'(blocks);
  assign in_range  = (33'(faddr_blk) >= 33'(base_block)) && (33'(faddr_blk) < heap_hi);

  assign run_next    = run + CNT_W'(1);
  assign found_start = (run == '0) ? di : start_q;
  assign di_next     = CNT_W'(di) + CNT_W'(1);
  assign addr_wide   = (64'(base_block) + 64'(start_q)) << SHIFT;

  always_comb begin
    mark = '0;
    mark[MARK_TAKEN] = 1'b1;
    mark[MARK_FIRST] = (wa == start_q);
    mark[MARK_NEXT]  = (wa != last_q);
  end

  always_comb begin
    wr_en   = (state == S_CLEAR) || (state == S_MARK) || ((state == S_FREE) && rv);
    wr_addr = (state == S_FREE) ? di : wa;
    wr_data = (state == S_MARK) ? mark : '0;
  end

  btff_mark_ram #(
    .DEPTH (MAX_BLOCKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .rd_en   (issue),
    .rd_addr (ra[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      wa         <= '0;
      clr_result <= 1'b0;
      rv         <= 1'b0;
    end else begin
      rv <= issue;
      if (issue) begin
        di <= ra[IDX_W-1:0];
        ra <= ra + CNT_W'(1);
      end
      case (state)
        S_CLEAR: begin
          if (wa == LAST_IDX) begin
            state <= clr_result ? S_DONE : S_IDLE;
          end else begin
            wa <= wa + IDX_W'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q    <= operation;
            bytes_q <= request_bytes;
            faddr_q <= free_address;
            state   <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_q.granted_address <= '0;
          run                   <= '0;
          case (op_q)
            OP_ALLOCATE: begin
              if (bytes_q == '0) begin
                res_q.status <= ST_ZERO_SIZE;
                state        <= S_DONE;
              end else if (want_full > 33'(blocks)) begin
                res_q.status <= ST_NO_MEMORY;
                state        <= S_DONE;
              end else begin
                res_q.status <= ST_OK;
                ra           <= '0;
                want_q       <= CNT_W'(want_full);
                state        <= S_SEARCH;
              end
            end
            OP_FREE: begin
              if (!in_range) begin
                res_q.status <= ST_BAD_ADDR;
                state        <= S_DONE;
              end else begin
                res_q.status <= ST_OK;
                ra           <= CNT_W'(faddr_blk - ADDR_W'(base_block));
                state        <= S_FREE;
              end
            end
            OP_CLEAR: begin
              res_q.status <= ST_OK;
              wa           <= '0;
              clr_result   <= 1'b1;
              state        <= S_CLEAR;
            end
            default: begin
              res_q.status <= ST_OK;
              state        <= S_DONE;
            end
          endcase
        end
        S_SEARCH: begin
          if (rv) begin
            if (rd_data[MARK_TAKEN]) begin
              run <= '0;
            end else begin
              run     <= run_next;
              start_q <= found_start;
              if (run_next == want_q) begin
                last_q <= di;
                wa     <= found_start;
                state  <= S_MARK;
              end
            end
          end else if (!issue) begin
            res_q.status <= ST_NO_MEMORY;
            state        <= S_DONE;
          end
        end
        S_MARK: begin
          if (wa == last_q) begin
            res_q.granted_address <= addr_wide[ADDR_W-1:0];
            state                 <= S_DONE;
          end else begin
            wa <= wa + IDX_W'(1);
          end
        end
        S_FREE: begin
          if (rv && !(rd_data[MARK_NEXT] && (di_next < blocks))) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            clr_result <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/block_table_first_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// block_table_first_fit_allocator
// First-fit heap block allocator with a block mark table in on-chip memory.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request word: operation, request_bytes, free_address.
//   m_axis returns one word per request: granted_address and status.
//   cfg_we/cfg_index/cfg_data write base_block (0) and block_count (1).
//   The user must do so while the block is idle; the block does not check it.
// Operation, n = min(block_count, MAX_BLOCKS):
//   allocate: scans entries for a free run, then marks the run's blocks;
//   all n entries are scanned when no run fits; the mark memory read port
//   paces the scan. free: releases the blocks along the chain.
//   clear: rewrites every entry, one memory write per cycle.
//   Zero size, oversize, bad address, unused codes: no scan. One at a time.
// Reset: a clearing sweep writes every mark to free; s_axis_tready stays
//   low until it ends.
// Stall: the result sits in an output register; s_axis may accept the next
//   word while it waits, but that word's result waits for the register.
// ----------------------------------------------------------------------------
module block_table_first_fit_allocator
  import btff_pkg::*;
#(
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // operation[1:0], request_bytes[33:2], free_address[65:34], zero fill
  input  logic [71:0]      s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // granted_address[31:0], status[33:32], zero fill
  output logic [39:0]      m_axis_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(MAX_BLOCKS);
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic [BASE_W-1:0]  base_block;
  logic [COUNT_W-1:0] block_count;
  logic [CNT_W-1:0]   blocks;
  logic               eng_idle;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  result_t            out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_block  <= '0;
      block_count <= COUNT_W'(COUNT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_BLOCK:  base_block  <= cfg_data[BASE_W-1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign blocks = (CMP_W'(block_count) > CMP_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                             : CNT_W'(block_count);

  assign s_axis_tready = eng_idle;
  assign res_ready     = !m_axis_tvalid || m_axis_tready;

  btff_engine #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (s_axis_tvalid && s_axis_tready),
    .operation     (s_axis_tdata[1:0]),
    .request_bytes (s_axis_tdata[33:2]),
    .free_address  (s_axis_tdata[65:34]),
    .base_block    (base_block),
    .blocks        (blocks),
    .res_ready     (res_ready),
    .idle          (eng_idle),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tdata = {6'b0, out_q.status, out_q.granted_address};

`include "block_table_first_fit_allocator_assert.svh"

  `BTFF_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a word while the engine was still busy")
  `BTFF_ASSERT_NOW(a_fail_zero_addr, m_axis_tvalid && (m_axis_tdata[33:32] != ST_OK), m_axis_tdata[31:0] == '0, "failed request carries an address")
  `BTFF_ASSERT_NOW(a_no_overwrite, res_valid, !m_axis_tvalid || m_axis_tready, "result overwrote a waiting word")

endmodule
